// ===== sv/ges_pkg.sv =====
// ----------------------------------------------------------------------------
// ges_pkg: shared types and constants for the grain envelope/pan setup
// Holds the division pipeline record, format constants and the cosine
// series used to build the pan table at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package ges_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF       = 20;
  localparam int PAN_TABLE_ENTRIES_DEF = 256;

  // field widths
  localparam int LEN_W   = 20;
  localparam int SHAPE_W = 16;
  localparam int PAN_W   = 16;
  localparam int DLY_W   = 21;
  localparam int STEP_W  = 32;
  localparam int SMTH_W  = 17;
  localparam int SLOPE_W = 16;
  localparam int STEEP_W = 13;
  localparam int RECIP_W = 24;
  localparam int GAIN_W  = 16;
  localparam int SDLY_W  = 20;

  // divider widths: quotient bits, partial remainder widths
  localparam int QUO_W     = 32;
  localparam int ENV_REM_W = LEN_W + QUO_W;
  localparam int RCP_REM_W = SLOPE_W + QUO_W;

  // slope limits, Q0.16
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = 16'd328;
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 16'd65208;

  // x/5 as (x * RECIP5_M) >> RECIP5_SH, exact for x < 2^19
  localparam logic [18:0] RECIP5_M  = 19'd419431;
  localparam int          RECIP5_SH = 21;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // one transaction moving down the divider chain
  typedef struct packed {
    logic [ENV_REM_W-1:0] env_rem;
    logic [LEN_W-1:0]     env_den;
    logic [QUO_W-1:0]     env_q;
    logic                 env_zero;
    logic [RCP_REM_W-1:0] att_rem;
    logic [SLOPE_W-1:0]   att_den;
    logic [QUO_W-1:0]     att_q;
    logic [RCP_REM_W-1:0] rel_rem;
    logic [SLOPE_W-1:0]   rel_den;
    logic [QUO_W-1:0]     rel_q;
    logic [SMTH_W-1:0]    smooth;
    logic [SLOPE_W-1:0]   slope;
    logic [STEEP_W-1:0]   steep;
    logic [GAIN_W-1:0]    left;
    logic [GAIN_W-1:0]    right;
    logic [SDLY_W-1:0]    delay;
  } chain_t;

  // cosine of a Q2.30 angle, Taylor series to x^12, rounded to Q1.15
  function automatic logic [15:0] pan_cos(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] rnd;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    term = (term * x2) / 64'd2;
    sum  = sum - $signed(term);
    term = (term * x2) / 64'd12;
    sum  = sum + $signed(term);
    term = (term * x2) / 64'd30;
    sum  = sum - $signed(term);
    term = (term * x2) / 64'd56;
    sum  = sum + $signed(term);
    term = (term * x2) / 64'd90;
    sum  = sum - $signed(term);
    term = (term * x2) / 64'd132;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 << 30)) begin
      sum = 64'sd1 << 30;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    return rnd[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/grain_envelope_pan_setup.sv =====
// ----------------------------------------------------------------------------
// grain_envelope_pan_setup: per-grain envelope, slope and pan coefficients
// Four front stages followed by a 32-stage bit-per-stage divider chain.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (lsb first)
//  s_axis   | in        | grain_length, shape_morph, pan_position, delay_request
//  m_axis   | out       | envelope_step ... start_delay (see port comment)
//
//  One transaction per cycle while the output is not held; results pass
//  four setup stages, then the 32 quotient stages of the envelope divider.
//  Synchronous reset clears all stage valid bits.
//  A held output stalls every stage at once; nothing moves or drops.
`default_nettype none

module grain_envelope_pan_setup #(
  parameter int COUNT_WIDTH       = ges_pkg::COUNT_WIDTH_DEF,
  parameter int PAN_TABLE_ENTRIES = ges_pkg::PAN_TABLE_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // grain_length[19:0], shape_morph[35:20], pan_position[51:36],
  // delay_request[72:52], zero fill [79:73]
  input  wire logic [79:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // envelope_step[31:0], smoothness[48:32], attack_fraction[64:49],
  // steepness[77:65], attack_reciprocal[101:78], release_reciprocal[125:102],
  // left_gain[141:126], right_gain[157:142], start_delay[177:158], zero [183:178]
  output logic [183:0]      m_axis_tdata
);

  localparam int STAGES = ges_pkg::QUO_W;

  logic en;
  ges_pkg::chain_t link [0:STAGES];
  logic            lv   [0:STAGES];
  ges_pkg::chain_t fin;
  logic [31:0]     env_step;

  // whole pipeline advances unless the output holds an untaken result
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  ges_front #(
    .COUNT_WIDTH       (COUNT_WIDTH),
    .PAN_TABLE_ENTRIES (PAN_TABLE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_axis_tvalid),
    .grain_length  (s_axis_tdata[19:0]),
    .shape_morph   (s_axis_tdata[35:20]),
    .pan_position  (s_axis_tdata[51:36]),
    .delay_request (s_axis_tdata[72:52]),
    .out_valid     (lv[0]),
    .out_data      (link[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < STAGES; i++) begin : g_div
    ges_div_stage #(
      .BIT (STAGES - 1 - i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lv[i]),
      .in_data   (link[i]),
      .out_valid (lv[i+1]),
      .out_data  (link[i+1])
    );
  end

  // output packing; zero length gives a full-scale step
  always_comb begin
    fin      = link[STAGES];
    env_step = fin.env_zero ? 32'h8000_0000 : fin.env_q;
    m_axis_tdata = {6'd0, fin.delay, fin.right, fin.left,
                    fin.rel_q[ges_pkg::RECIP_W-1:0], fin.att_q[ges_pkg::RECIP_W-1:0],
                    fin.steep, fin.slope, fin.smooth, env_step};
  end

  assign m_axis_tvalid = lv[STAGES];

endmodule

`default_nettype wire

// ===== sv/ges_front.sv =====
// ----------------------------------------------------------------------------
// ges_front: shape zones, pan interpolation, delay clamp, divider setup
// Four register stages ahead of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ges_front #(
  parameter int COUNT_WIDTH       = ges_pkg::COUNT_WIDTH_DEF,
  parameter int PAN_TABLE_ENTRIES = ges_pkg::PAN_TABLE_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [ges_pkg::LEN_W-1:0]   grain_length,
  input  wire logic [ges_pkg::SHAPE_W-1:0] shape_morph,
  input  wire logic [ges_pkg::PAN_W-1:0]   pan_position,
  input  wire logic [ges_pkg::DLY_W-1:0]   delay_request,
  output logic                             out_valid,
  output ges_pkg::chain_t                  out_data
);

  localparam int N     = PAN_TABLE_ENTRIES;
  localparam int TW    = $clog2(N + 1);
  localparam int POS_W = 17 + TW;
  localparam logic [ges_pkg::LEN_W-1:0] CNT_MASK =
    (COUNT_WIDTH >= ges_pkg::LEN_W) ? {ges_pkg::LEN_W{1'b1}}
                                    : ges_pkg::LEN_W'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [TW-1:0] LAST = TW'(N);

  // quarter-cosine table, built at elaboration
  logic [15:0] pan_table [0:N];
  for (genvar k = 0; k <= N; k++) begin : g_tab
    localparam logic [63:0] XK = (64'(k) * ges_pkg::HALF_PI_Q30 + 64'(N / 2)) / 64'(N);
    assign pan_table[k] = ges_pkg::pan_cos(XK);
  end

  // ---------------- stage 1: zones, pan position, delay
  logic                          v1;
  logic [ges_pkg::LEN_W-1:0]     len1;
  logic [ges_pkg::SDLY_W-1:0]    dly1;
  logic [20:0]                   x20_1;
  logic [ges_pkg::SMTH_W-1:0]    smooth1;
  logic [ges_pkg::STEEP_W-1:0]   steep1;
  logic [TW-1:0]                 idx_l1, idx_r1;
  logic [15:0]                   frac_l1, frac_r1;

  logic [17:0]                   t3;
  logic [20:0]                   x20_c;
  logic [20:0]                   steep_c;
  logic [ges_pkg::SMTH_W-1:0]    smooth_c;
  logic [16:0]                   u_l, u_r;
  logic [POS_W-1:0]              pos_l, pos_r;
  logic [ges_pkg::SDLY_W-1:0]    dly_c;

  always_comb begin
    t3 = 18'(shape_morph) * 18'd3;
    if (t3 < 18'd65536) begin
      x20_c    = 21'd655370 - 21'(t3) * 21'd9;
      steep_c  = (21'd655424 - 21'(t3) * 21'd9) >> 7;
      smooth_c = '0;
    end else if (t3 < 18'd131072) begin
      x20_c    = 21'd65546 + 21'(t3 - 18'd65536) * 21'd9;
      steep_c  = (21'd131200 - 21'(t3 - 18'd65536)) >> 8;
      smooth_c = 17'(t3 - 18'd65536);
    end else begin
      x20_c    = 21'd655368 + 21'(t3 - 18'd131072) * 21'd8;
      steep_c  = 21'd256;
      smooth_c = 17'd65536;
    end
    u_l   = {1'b0, ~pan_position[15], pan_position[14:0]};
    u_r   = 17'h10000 - u_l;
    pos_l = POS_W'(u_l) * POS_W'(N);
    pos_r = POS_W'(u_r) * POS_W'(N);
    // negative requests give zero, long ones saturate
    if (delay_request[ges_pkg::DLY_W-1]) begin
      dly_c = '0;
    end else if (delay_request[ges_pkg::SDLY_W-1:0] > CNT_MASK) begin
      dly_c = CNT_MASK;
    end else begin
      dly_c = delay_request[ges_pkg::SDLY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len1    <= grain_length & CNT_MASK;
      dly1    <= dly_c;
      x20_1   <= x20_c;
      smooth1 <= smooth_c;
      steep1  <= steep_c[ges_pkg::STEEP_W-1:0];
      idx_l1  <= pos_l[16 +: TW];
      idx_r1  <= pos_r[16 +: TW];
      frac_l1 <= pos_l[15:0];
      frac_r1 <= pos_r[15:0];
    end
  end

  // ---------------- stage 2: slope divide by 20 and clamp, table reads
  logic                          v2;
  logic [ges_pkg::LEN_W-1:0]     len2;
  logic [ges_pkg::SDLY_W-1:0]    dly2;
  logic [ges_pkg::SMTH_W-1:0]    smooth2;
  logic [ges_pkg::STEEP_W-1:0]   steep2;
  logic [ges_pkg::SLOPE_W-1:0]   slope2;
  logic [15:0]                   a_l2, a_r2, dif_l2, dif_r2, frac_l2, frac_r2;
  logic                          up_l2, up_r2;

  logic [37:0]                   sl_prod;
  logic [16:0]                   sl_raw;
  logic [ges_pkg::SLOPE_W-1:0]   sl_c;
  logic [TW-1:0]                 ia_l, ib_l, ia_r, ib_r;
  logic [15:0]                   ta_l, tb_l, ta_r, tb_r;

  always_comb begin
    sl_prod = 38'(x20_1[20:2]) * 38'(ges_pkg::RECIP5_M);
    sl_raw  = sl_prod[ges_pkg::RECIP5_SH +: 17];
    if (sl_raw < 17'(ges_pkg::SLOPE_MIN)) begin
      sl_c = ges_pkg::SLOPE_MIN;
    end else if (sl_raw > 17'(ges_pkg::SLOPE_MAX)) begin
      sl_c = ges_pkg::SLOPE_MAX;
    end else begin
      sl_c = sl_raw[15:0];
    end
    // past the end both reads take the last entry
    ia_l = (idx_l1 >= LAST) ? LAST : idx_l1;
    ib_l = (idx_l1 >= LAST) ? LAST : idx_l1 + TW'(1);
    ia_r = (idx_r1 >= LAST) ? LAST : idx_r1;
    ib_r = (idx_r1 >= LAST) ? LAST : idx_r1 + TW'(1);
    ta_l = pan_table[ia_l];
    tb_l = pan_table[ib_l];
    ta_r = pan_table[ia_r];
    tb_r = pan_table[ib_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len2    <= len1;
      dly2    <= dly1;
      smooth2 <= smooth1;
      steep2  <= steep1;
      slope2  <= sl_c;
      a_l2    <= ta_l;
      a_r2    <= ta_r;
      up_l2   <= (tb_l > ta_l);
      up_r2   <= (tb_r > ta_r);
      dif_l2  <= (tb_l > ta_l) ? tb_l - ta_l : ta_l - tb_l;
      dif_r2  <= (tb_r > ta_r) ? tb_r - ta_r : ta_r - tb_r;
      frac_l2 <= (idx_l1 >= LAST) ? 16'd0 : frac_l1;
      frac_r2 <= (idx_r1 >= LAST) ? 16'd0 : frac_r1;
    end
  end

  // ---------------- stage 3: interpolation products, divider operands
  logic                          v3;
  logic [ges_pkg::SDLY_W-1:0]    dly3;
  logic [ges_pkg::SMTH_W-1:0]    smooth3;
  logic [ges_pkg::STEEP_W-1:0]   steep3;
  logic [ges_pkg::SLOPE_W-1:0]   slope3;
  logic [15:0]                   a_l3, a_r3, st_l3, st_r3;
  logic                          up_l3, up_r3;
  logic [ges_pkg::LEN_W-1:0]     len3;

  logic [32:0]                   pr_l, pr_r;

  always_comb begin
    pr_l = 33'(dif_l2) * 33'(frac_l2) + 33'd32768;
    pr_r = 33'(dif_r2) * 33'(frac_r2) + 33'd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly3    <= dly2;
      smooth3 <= smooth2;
      steep3  <= steep2;
      slope3  <= slope2;
      len3    <= len2;
      a_l3    <= a_l2;
      a_r3    <= a_r2;
      up_l3   <= up_l2;
      up_r3   <= up_r2;
      st_l3   <= pr_l[31:16];
      st_r3   <= pr_r[31:16];
    end
  end

  // ---------------- stage 4: gains, divider start values
  ges_pkg::chain_t nxt;

  always_comb begin
    nxt          = '0;
    nxt.env_rem  = ges_pkg::ENV_REM_W'(33'h0_8000_0000 + 33'(len3 >> 1));
    nxt.env_den  = len3;
    nxt.env_zero = (len3 == '0);
    nxt.att_rem  = ges_pkg::RCP_REM_W'(34'h1_0000_0000 + 34'(slope3 >> 1));
    nxt.att_den  = slope3;
    nxt.rel_rem  = ges_pkg::RCP_REM_W'(34'h1_0000_0000
                                       + 34'((17'h10000 - 17'(slope3)) >> 1));
    nxt.rel_den  = 16'(17'h10000 - 17'(slope3));
    nxt.smooth   = smooth3;
    nxt.slope    = slope3;
    nxt.steep    = steep3;
    nxt.left     = up_l3 ? a_l3 + st_l3 : a_l3 - st_l3;
    nxt.right    = up_r3 ? a_r3 + st_r3 : a_r3 - st_r3;
    nxt.delay    = dly3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ges_div_stage.sv =====
// ----------------------------------------------------------------------------
// ges_div_stage: one quotient bit of the three restoring dividers
// Settles bit BIT of the envelope step and of both reciprocals.
// ----------------------------------------------------------------------------
`default_nettype none

module ges_div_stage #(
  parameter int BIT = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire ges_pkg::chain_t in_data,
  output logic                 out_valid,
  output ges_pkg::chain_t      out_data
);

  ges_pkg::chain_t nxt;
  logic [ges_pkg::ENV_REM_W-1:0] env_thr;
  logic [ges_pkg::RCP_REM_W-1:0] att_thr, rel_thr;

  // trial subtract of the shifted divisor
  always_comb begin
    nxt     = in_data;
    env_thr = ges_pkg::ENV_REM_W'(in_data.env_den) << BIT;
    att_thr = ges_pkg::RCP_REM_W'(in_data.att_den) << BIT;
    rel_thr = ges_pkg::RCP_REM_W'(in_data.rel_den) << BIT;
    if (in_data.env_rem >= env_thr) begin
      nxt.env_rem    = in_data.env_rem - env_thr;
      nxt.env_q[BIT] = 1'b1;
    end
    if (in_data.att_rem >= att_thr) begin
      nxt.att_rem    = in_data.att_rem - att_thr;
      nxt.att_q[BIT] = 1'b1;
    end
    if (in_data.rel_rem >= rel_thr) begin
      nxt.rel_rem    = in_data.rel_rem - rel_thr;
      nxt.rel_q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ges_checker.sv =====
// ----------------------------------------------------------------------------
// ges_checker: port-level checks for grain_envelope_pan_setup
// Watches handshake and result ranges; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ges_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [183:0] m_axis_tdata
);

  // a held result keeps its valid
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // input side is ready exactly when the output can move
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // no result right after reset
  assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // slope lies within its clamp
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[64:49] >= 16'd328) && (m_axis_tdata[64:49] <= 16'd65208))
    else $error("attack fraction out of range");

  // steepness lies between one and twenty
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[77:65] >= 13'd256) && (m_axis_tdata[77:65] <= 13'd5120))
    else $error("steepness out of range");

endmodule

bind grain_envelope_pan_setup ges_checker u_ges_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for grain_envelope_pan_setup
// Drives grain triggers through the input stream, predicts every coefficient
// set in fixed point and compares each output transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
  logic [19:0] start_delay;
  logic [15:0] right_gain;
  logic [15:0] left_gain;
  logic [23:0] release_reciprocal;
  logic [23:0] attack_reciprocal;
  logic [12:0] steepness;
  logic [15:0] attack_fraction;
  logic [16:0] smoothness;
  logic [31:0] envelope_step;
} grain_coef_t;

class grain_coef_board;
  grain_coef_t pending[$];
  logic [15:0] cos_tab[0:256];
  int errors;

  function new();
    logic [63:0] x, x2, term;
    logic signed [63:0] acc;
    errors = 0;
    // quarter-cosine table, truncated Taylor series in Q2.30
    for (int k = 0; k <= 256; k++) begin
      x = (k * ges_pkg::HALF_PI_Q30 + 64'd128) / 64'd256;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      acc = 64'sd1 << 30;
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
      cos_tab[k] = 16'(($unsigned(acc) + 64'd16384) >> 15);
    end
  endfunction

  function logic [15:0] gain_at(logic [16:0] u);
    logic [31:0] pos, idx, frac, a, b;
    pos = u * 256;
    idx = pos >> 16;
    frac = pos & 32'hFFFF;
    if (idx >= 256) return cos_tab[256];
    a = cos_tab[idx];
    b = cos_tab[idx + 1];
    if (a >= b) return 16'(a - (((a - b) * frac + 32768) >> 16));
    return 16'(a + (((b - a) * frac + 32768) >> 16));
  endfunction

  function logic [23:0] recip(logic [31:0] d);
    logic [63:0] r;
    if (d == 0) return 24'hFFFFFF;
    r = ((64'd1 << 32) + (d >> 1)) / d;
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  // note an accepted trigger and queue its coefficients
  function void note_trigger(logic [19:0] len, logic [15:0] shape,
                             logic [15:0] pan, logic [20:0] dly);
    grain_coef_t c;
    logic [31:0] t3, t, slope;
    logic [16:0] p;
    c.envelope_step = (len == 0) ? 32'h80000000
                      : 32'(((64'd1 << 31) + (len >> 1)) / len);
    t3 = 3 * shape;
    if (t3 < 65536) begin
      t = t3;
      c.smoothness = 0;
      slope = (655360 - 9 * t + 10) / 20;
      c.steepness = 13'((655360 - 9 * t + 64) / 128);
    end else if (t3 < 131072) begin
      t = t3 - 65536;
      c.smoothness = 17'(t);
      slope = (65536 + 9 * t + 10) / 20;
      c.steepness = 13'((131072 - t + 128) / 256);
    end else begin
      t = t3 - 131072;
      c.smoothness = 17'd65536;
      slope = (163840 + 2 * t + 2) / 5;
      c.steepness = 13'd256;
    end
    if (slope < 328) slope = 328;
    if (slope > 65208) slope = 65208;
    c.attack_fraction = slope[15:0];
    c.attack_reciprocal = recip(slope);
    c.release_reciprocal = recip(65536 - slope);
    p = {1'b0, pan ^ 16'h8000};
    c.left_gain = gain_at(p);
    c.right_gain = gain_at(17'd65536 - p);
    c.start_delay = dly[20] ? 20'd0 : dly[19:0];
    pending.push_back(c);
  endfunction

  function void check_result(grain_coef_t got);
    grain_coef_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transaction %h", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.envelope_step !== e.envelope_step) begin
      $error("envelope_step exp %0d got %0d", e.envelope_step, got.envelope_step);
      errors++;
    end
    if (got.smoothness !== e.smoothness) begin
      $error("smoothness exp %0d got %0d", e.smoothness, got.smoothness);
      errors++;
    end
    if (got.attack_fraction !== e.attack_fraction) begin
      $error("attack_fraction exp %0d got %0d", e.attack_fraction, got.attack_fraction);
      errors++;
    end
    if (got.steepness !== e.steepness) begin
      $error("steepness exp %0d got %0d", e.steepness, got.steepness);
      errors++;
    end
    if (got.attack_reciprocal !== e.attack_reciprocal) begin
      $error("attack_reciprocal exp %0d got %0d", e.attack_reciprocal,
             got.attack_reciprocal);
      errors++;
    end
    if (got.release_reciprocal !== e.release_reciprocal) begin
      $error("release_reciprocal exp %0d got %0d", e.release_reciprocal,
             got.release_reciprocal);
      errors++;
    end
    if (got.left_gain !== e.left_gain) begin
      $error("left_gain exp %0d got %0d", e.left_gain, got.left_gain);
      errors++;
    end
    if (got.right_gain !== e.right_gain) begin
      $error("right_gain exp %0d got %0d", e.right_gain, got.right_gain);
      errors++;
    end
    if (got.start_delay !== e.start_delay) begin
      $error("start_delay exp %0d got %0d", e.start_delay, got.start_delay);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [183:0] m_axis_tdata;

  grain_coef_board board;
  int send_idle_pct;
  int recv_stall_pct;

  grain_envelope_pan_setup u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stalls, check every accepted result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result(grain_coef_t'(m_axis_tdata[177:0]));
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one trigger, with a random idle gap ahead of it
  task automatic send_trigger(logic [19:0] len, logic [15:0] shape,
                              logic [15:0] pan, logic [20:0] dly);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, dly, pan, shape, len};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_trigger(len, shape, pan, dly);
  endtask

  task automatic send_random(int count);
    logic [19:0] len;
    for (int i = 0; i < count; i++) begin
      // mostly short lengths, some full range
      case ($urandom_range(3))
        0: len = 20'($urandom_range(16));
        1: len = 20'($urandom);
        default: len = 20'($urandom_range(4095));
      endcase
      send_trigger(len, 16'($urandom), 16'($urandom), 21'($urandom));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, shape zone edges, pan ends, delay clamp
    send_trigger(20'd0, 16'd0, 16'h8000, 21'h100000);
    send_trigger(20'd1, 16'hFFFF, 16'h7FFF, 21'h0FFFFF);
    send_trigger(20'hFFFFF, 16'd21845, 16'd0, 21'h1FFFFF);
    send_trigger(20'd2, 16'd21846, 16'h0001, 21'd0);
    send_trigger(20'd3, 16'd43690, 16'hFFFF, 21'd1);
    send_trigger(20'd4, 16'd43691, 16'hC000, 21'd1000);
    send_trigger(20'd5, 16'd65000, 16'h4000, 21'h155555);
    send_trigger(20'hAAAAA, 16'h5555, 16'h5555, 21'h0AAAAA);
    send_trigger(20'h55555, 16'hAAAA, 16'hAAAA, 21'h155555);
    send_trigger(20'd3, 16'd1, 16'h8001, 21'h1FFFFE);
    send_trigger(20'd7, 16'd65534, 16'h7FFE, 21'd2);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(425);
    send_idle_pct = 55; recv_stall_pct = 0;  send_random(425);
    // hold off until the pipe is empty
    drain();
    send_idle_pct = 0;  recv_stall_pct = 55; send_random(425);
    send_idle_pct = 11; recv_stall_pct = 11; send_random(425);
    drain();
    repeat (50) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
